FILE: rtl/pib_pkg.sv
package pib_pkg;

	localparam int COORD_BITS  = 16;
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int MAG_W       = CROSS_W;
	localparam int WEIGHT_FRAC = 16;
	localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
	localparam int REG_IDX_W   = 3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_A_U = 3'd0,
		REG_A_V = 3'd1,
		REG_B_U = 3'd2,
		REG_B_V = 3'd3,
		REG_C_U = 3'd4,
		REG_C_V = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] point_u;
		logic [COORD_BITS-1:0] point_v;
	} in_item_t;

	typedef struct packed {
		logic                inside_res;
		logic [WEIGHT_W-1:0] weight_a;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_c;
	} out_item_t;

	// state of the two restoring dividers, one quotient bit per stage
	typedef struct packed {
		logic                   valid;
		logic                   hit;
		logic                   one1;
		logic                   one2;
		logic [MAG_W-1:0]       den;
		logic [MAG_W-1:0]       r1;
		logic [MAG_W-1:0]       r2;
		logic [WEIGHT_FRAC-1:0] q1;
		logic [WEIGHT_FRAC-1:0] q2;
	} div_t;

	function automatic logic signed [DIFF_W-1:0] sdiff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

endpackage

FILE: rtl/pib_div_step.sv
module pib_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  pib_pkg::div_t din,
	output pib_pkg::div_t dout
);
	import pib_pkg::*;

	div_t             step_s;
	logic             vld_s;
	div_t             nxt;
	logic [MAG_W:0]   sh1, sh2;
	logic [MAG_W+1:0] df1, df2;

	always_comb begin
		nxt = din;
		sh1 = {din.r1, 1'b0};
		sh2 = {din.r2, 1'b0};
		df1 = {1'b0, sh1} - {2'b00, din.den};
		df2 = {1'b0, sh2} - {2'b00, din.den};
		if (!df1[MAG_W+1]) begin
			nxt.r1 = df1[MAG_W-1:0];
			nxt.q1 = {din.q1[WEIGHT_FRAC-2:0], 1'b1};
		end else begin
			nxt.r1 = sh1[MAG_W-1:0];
			nxt.q1 = {din.q1[WEIGHT_FRAC-2:0], 1'b0};
		end
		if (!df2[MAG_W+1]) begin
			nxt.r2 = df2[MAG_W-1:0];
			nxt.q2 = {din.q2[WEIGHT_FRAC-2:0], 1'b1};
		end else begin
			nxt.r2 = sh2[MAG_W-1:0];
			nxt.q2 = {din.q2[WEIGHT_FRAC-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s <= nxt;
		end
	end

	always_comb begin
		dout       = step_s;
		dout.valid = vld_s;
	end

endmodule

FILE: rtl/point_in_triangle_barycentric.sv
// channel  | handshake          | payload
// in       | in_valid/in_stall  | in_data   (point_u, point_v)
// out      | out_valid/out_stall| out_data  (inside_res, weight_a..c)
// cfg      | cfg_wen            | cfg_idx, cfg_wdata (vertex registers)
//
// One item per cycle unless stalled, through five front stages (edge
// vectors, products, cross products, magnitudes, divider setup), 16
// one-bit divider stages for the two weights and one output stage.
// arst_n clears the vertex registers and all stage valid bits.
// The whole pipe holds while a result waits under out_stall; in_stall follows.
module point_in_triangle_barycentric (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pib_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output pib_pkg::out_item_t                  out_data,
	input  logic                                cfg_wen,
	input  logic [pib_pkg::REG_IDX_W-1:0]       cfg_idx,
	input  logic [pib_pkg::COORD_BITS-1:0]      cfg_wdata
);
	import pib_pkg::*;

	localparam int NCROSS    = 5;
	localparam int X_ZH      = 0;
	localparam int X_ZS      = 1;
	localparam int X_ZQ      = 2;
	localparam int X_N1      = 3;
	localparam int X_DEN     = 4;
	localparam int DIV_STEPS = WEIGHT_FRAC;

	logic [COORD_BITS-1:0] a_u_q, a_v_q, b_u_q, b_v_q, c_u_q, c_v_q;

	logic en;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s22;
	logic signed [DIFF_W-1:0] la_s1 [NCROSS];
	logic signed [DIFF_W-1:0] lb_s1 [NCROSS];
	logic signed [DIFF_W-1:0] ra_s1 [NCROSS];
	logic signed [DIFF_W-1:0] rb_s1 [NCROSS];
	logic signed [PROD_W-1:0] pl_s2 [NCROSS];
	logic signed [PROD_W-1:0] pr_s2 [NCROSS];
	logic signed [CROSS_W-1:0] cr_s3 [NCROSS];
	logic                     inside_s4;
	logic [MAG_W-1:0]         den_s4, num1_s4, num2_s4;
	div_t                     d_s5;
	out_item_t                out_s22;

	logic signed [DIFF_W-1:0] pa_u, pa_v, pb_u, pb_v, pc_u, pc_v;
	logic signed [DIFF_W-1:0] ba_u, ba_v, cb_u, cb_v, ac_u, ac_v, ca_u, ca_v;
	logic [NCROSS-1:0]        pos, neg;
	logic [MAG_W-1:0]         mag [NCROSS];
	logic                     one1, one2;
	logic [WEIGHT_W-1:0]      w1, w2;
	logic [WEIGHT_W:0]        wsum;
	out_item_t                res;
	div_t                     dp [DIV_STEPS+1];

	// vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_u_q <= '0;
			a_v_q <= '0;
			b_u_q <= '0;
			b_v_q <= '0;
			c_u_q <= '0;
			c_v_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_A_U: a_u_q <= cfg_wdata;
				REG_A_V: a_v_q <= cfg_wdata;
				REG_B_U: b_u_q <= cfg_wdata;
				REG_B_V: b_v_q <= cfg_wdata;
				REG_C_U: c_u_q <= cfg_wdata;
				REG_C_V: c_v_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en       = !(v_s22 && out_stall);
	assign in_stall = !en;

	// stage 1: difference vectors
	always_comb begin
		pa_u = sdiff(in_data.point_u, a_u_q);
		pa_v = sdiff(in_data.point_v, a_v_q);
		pb_u = sdiff(in_data.point_u, b_u_q);
		pb_v = sdiff(in_data.point_v, b_v_q);
		pc_u = sdiff(in_data.point_u, c_u_q);
		pc_v = sdiff(in_data.point_v, c_v_q);
		ba_u = sdiff(b_u_q, a_u_q);
		ba_v = sdiff(b_v_q, a_v_q);
		cb_u = sdiff(c_u_q, b_u_q);
		cb_v = sdiff(c_v_q, b_v_q);
		ac_u = sdiff(a_u_q, c_u_q);
		ac_v = sdiff(a_v_q, c_v_q);
		ca_u = sdiff(c_u_q, a_u_q);
		ca_v = sdiff(c_v_q, a_v_q);
	end

	// cross(x, y) = x.u * y.v - x.v * y.u
	always_ff @(posedge clk) begin
		if (en) begin
			la_s1[X_ZH]  <= ba_u; lb_s1[X_ZH]  <= pa_v; ra_s1[X_ZH]  <= ba_v; rb_s1[X_ZH]  <= pa_u;
			la_s1[X_ZS]  <= cb_u; lb_s1[X_ZS]  <= pb_v; ra_s1[X_ZS]  <= cb_v; rb_s1[X_ZS]  <= pb_u;
			la_s1[X_ZQ]  <= ac_u; lb_s1[X_ZQ]  <= pc_v; ra_s1[X_ZQ]  <= ac_v; rb_s1[X_ZQ]  <= pc_u;
			la_s1[X_N1]  <= pa_u; lb_s1[X_N1]  <= ca_v; ra_s1[X_N1]  <= pa_v; rb_s1[X_N1]  <= ca_u;
			la_s1[X_DEN] <= ba_u; lb_s1[X_DEN] <= ca_v; ra_s1[X_DEN] <= ba_v; rb_s1[X_DEN] <= ca_u;
			// stage 2: products
			for (int i = 0; i < NCROSS; i++) begin
				pl_s2[i] <= la_s1[i] * lb_s1[i];
				pr_s2[i] <= ra_s1[i] * rb_s1[i];
			end
			// stage 3: cross products
			for (int i = 0; i < NCROSS; i++) begin
				cr_s3[i] <= CROSS_W'(pl_s2[i]) - CROSS_W'(pr_s2[i]);
			end
			// stage 4: inside test, magnitudes
			inside_s4 <= (&pos[X_ZQ:X_ZH]) || (&neg[X_ZQ:X_ZH]);
			den_s4    <= mag[X_DEN];
			num1_s4   <= (neg[X_N1] == neg[X_DEN]) ? mag[X_N1] : '0;
			num2_s4   <= (neg[X_ZH] == neg[X_DEN]) ? mag[X_ZH] : '0;
			// stage 5: divider setup
			d_s5.valid  <= 1'b0;
			d_s5.hit    <= inside_s4;
			d_s5.one1   <= one1;
			d_s5.one2   <= one2;
			d_s5.den    <= den_s4;
			d_s5.r1     <= one1 ? '0 : num1_s4;
			d_s5.r2     <= one2 ? '0 : num2_s4;
			d_s5.q1     <= '0;
			d_s5.q2     <= '0;
			// last stage: output
			out_s22 <= res;
		end
	end

	always_comb begin
		for (int i = 0; i < NCROSS; i++) begin
			neg[i] = cr_s3[i][CROSS_W-1];
			pos[i] = !cr_s3[i][CROSS_W-1] && (|cr_s3[i]);
			mag[i] = neg[i] ? MAG_W'(-cr_s3[i]) : MAG_W'(cr_s3[i]);
		end
	end

	assign one1 = num1_s4 >= den_s4;
	assign one2 = num2_s4 >= den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s22 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s22 <= dp[DIV_STEPS].valid;
		end
	end

	always_comb begin
		dp[0]       = d_s5;
		dp[0].valid = v_s5;
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		pib_div_step u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.din   (dp[g]),
			.dout  (dp[g+1])
		);
	end

	always_comb begin
		w1   = dp[DIV_STEPS].one1 ? WEIGHT_ONE : {1'b0, dp[DIV_STEPS].q1};
		w2   = dp[DIV_STEPS].one2 ? WEIGHT_ONE : {1'b0, dp[DIV_STEPS].q2};
		wsum = {1'b0, w1} + {1'b0, w2};
		res  = '0;
		if (dp[DIV_STEPS].hit) begin
			res.inside_res = 1'b1;
			res.weight_b   = w1;
			res.weight_c   = w2;
			res.weight_a   = (wsum > {1'b0, WEIGHT_ONE}) ? '0
				: WEIGHT_W'({1'b0, WEIGHT_ONE} - wsum);
		end
	end

	assign out_valid = v_s22;
	assign out_data  = out_s22;

`ifndef SYNTHESIS
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.inside_res |->
			out_data.weight_a == '0 && out_data.weight_b == '0 && out_data.weight_c == '0)
		else $error("outside item with nonzero weight");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_res |->
			({2'b00, out_data.weight_a} + {2'b00, out_data.weight_b}
			+ {2'b00, out_data.weight_c}) == {2'b00, WEIGHT_ONE})
		else $error("inside weights do not sum to one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held result changed");
`endif

endmodule
